// ===== sv/char_lcd_shadow_diff_writer_macros.svh =====
// Assertion macros for the character LCD shadow diff writer.
`ifndef CHAR_LCD_SHADOW_DIFF_WRITER_MACROS_SVH
`define CHAR_LCD_SHADOW_DIFF_WRITER_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define CLDW_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define CLDW_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/cldw_pkg.sv =====
// Shared types, opcodes and constants of the character LCD shadow diff writer.
`timescale 1ns / 1ps
package cldw_pkg;

  typedef enum logic [2:0] {
    KIND_DRAW      = 3'd0,
    KIND_CURSOR    = 3'd1,
    KIND_CLEAR     = 3'd2,
    KIND_BRIGHT    = 3'd3,
    KIND_ON        = 3'd4,
    KIND_OFF       = 3'd5,
    KIND_BLINK_ON  = 3'd6,
    KIND_BLINK_OFF = 3'd7
  } cldw_kind_e;

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 5;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_COLS = 1'b0,
    CFG_ROWS = 1'b1
  } cldw_cfg_e;

  localparam logic [4:0] COLS_RST = 5'd20;
  localparam logic [2:0] ROWS_RST = 3'd4;

  localparam logic [7:0] CMD_PREFIX   = 8'hFE;
  localparam logic [7:0] OP_MOVE      = 8'h45;
  localparam logic [7:0] OP_CLEAR     = 8'h51;
  localparam logic [7:0] OP_BRIGHT    = 8'h53;
  localparam logic [7:0] OP_ON        = 8'h41;
  localparam logic [7:0] OP_OFF       = 8'h42;
  localparam logic [7:0] OP_BLINK_ON  = 8'h4B;
  localparam logic [7:0] OP_BLINK_OFF = 8'h4C;
  localparam logic [7:0] CHAR_SPACE   = 8'h20;
  localparam logic [7:0] LEVEL_MIN    = 8'd1;
  localparam logic [7:0] LEVEL_MAX    = 8'd8;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // One queued request: up to four bytes, bytes[0] goes out first.
  typedef struct packed {
    logic [3:0][7:0] bytes;
    logic [1:0]      last_idx;
  } cldw_entry_t;

  typedef struct packed {
    logic        valid;
    cldw_entry_t entry;
  } cldw_push_t;

  // DDRAM address of the first column of each row.
  function automatic logic [7:0] row_base(input logic [1:0] r);
    logic [7:0] base;
    unique case (r)
      2'd0: base = 8'h00;
      2'd1: base = 8'h40;
      2'd2: base = 8'h14;
      2'd3: base = 8'h54;
    endcase
    return base;
  endfunction

endpackage

// ===== sv/cldw_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module cldw_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 80
) (
  input  logic                                   clk_i,
  input  logic                                   we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                       wdata_i,
  input  logic                                   re_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                       rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== sv/cldw_front.sv =====
// Front end: accepts requests, tracks both cursors and the shadow screen, builds byte groups.
`timescale 1ns / 1ps
module cldw_front #(
  parameter int MAX_COLS = 20,
  parameter int MAX_ROWS = 4
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic [4:0]             cfg_cols_i,
  input  logic [2:0]             cfg_rows_i,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  cldw_pkg::cldw_kind_e   kind_i,
  input  logic [7:0]             char_byte_i,
  input  logic [7:0]             col_i,
  input  logic [7:0]             row_i,
  input  logic [7:0]             level_i,
  input  logic                   q_full_i,
  output cldw_pkg::cldw_push_t   push_o
);

  localparam int ColW  = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int RowW  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int Depth = MAX_ROWS * MAX_COLS;
  localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1;

  localparam logic [7:0] LEVEL_MIN_C = cldw_pkg::LEVEL_MIN;
  localparam logic [7:0] LEVEL_MAX_C = cldw_pkg::LEVEL_MAX;

  function automatic logic [RowW+ColW-1:0] step_pos(input logic [ColW-1:0] c,
                                                    input logic [RowW-1:0] r,
                                                    input logic [4:0]      nc,
                                                    input logic [2:0]      nr);
    logic [5:0]      c1;
    logic [3:0]      r1;
    logic [ColW-1:0] cn;
    logic [RowW-1:0] rn;
    c1 = 6'(c) + 6'd1;
    r1 = 4'(r) + 4'd1;
    cn = ColW'(c1);
    rn = r;
    if (c1 >= 6'(nc)) begin
      cn = '0;
      rn = (r1 >= 4'(nr)) ? '0 : RowW'(r1);
    end
    return {rn, cn};
  endfunction

  logic [4:0] cols_eff;
  logic [2:0] rows_eff;

  always_comb begin
    if (cfg_cols_i == 5'd0) begin
      cols_eff = 5'd1;
    end else if (cfg_cols_i > 5'(MAX_COLS)) begin
      cols_eff = 5'(MAX_COLS);
    end else begin
      cols_eff = cfg_cols_i;
    end
    if (cfg_rows_i == 3'd0) begin
      rows_eff = 3'd1;
    end else if (cfg_rows_i > 3'(MAX_ROWS)) begin
      rows_eff = 3'(MAX_ROWS);
    end else begin
      rows_eff = cfg_rows_i;
    end
  end

  // ---------------- accept stage: logical cursor ----------------
  logic [ColW-1:0] lcol_q, lcol_d;
  logic [RowW-1:0] lrow_q, lrow_d;
  logic            accept;
  logic            in_area;
  logic [ColW-1:0] clamp_col;
  logic [RowW-1:0] clamp_row;
  logic [ColW-1:0] tgt_col;
  logic [RowW-1:0] tgt_row;
  logic [7:0]      level_clamp;
  logic [AddrW-1:0] addr_a;

  // B-stage registers
  logic                 b_valid_q;
  cldw_pkg::cldw_kind_e b_kind_q;
  logic [7:0]           b_char_q;
  logic [ColW-1:0]      b_col_q;
  logic [RowW-1:0]      b_row_q;
  logic [7:0]           b_level_q;
  logic                 b_hit_q;
  logic [AddrW-1:0]     b_addr_q;
  logic                 b_fwd_q;
  logic [7:0]           b_fwd_data_q;

  logic b_adv;
  logic wr_en;

  assign b_adv      = b_valid_q && !q_full_i;
  assign in_stall_o = b_valid_q && q_full_i;
  assign accept     = in_valid_i && !in_stall_o;

  assign in_area   = (3'(lrow_q) < rows_eff) && (5'(lcol_q) < cols_eff);
  assign clamp_col = (col_i < 8'(cols_eff)) ? ColW'(col_i) : ColW'(cols_eff - 5'd1);
  assign clamp_row = (row_i < 8'(rows_eff)) ? RowW'(row_i) : RowW'(rows_eff - 3'd1);
  assign addr_a    = AddrW'(lrow_q) * AddrW'(MAX_COLS) + AddrW'(lcol_q);

  always_comb begin
    if (level_i < LEVEL_MIN_C) begin
      level_clamp = LEVEL_MIN_C;
    end else if (level_i > LEVEL_MAX_C) begin
      level_clamp = LEVEL_MAX_C;
    end else begin
      level_clamp = level_i;
    end
  end

  always_comb begin
    lcol_d  = lcol_q;
    lrow_d  = lrow_q;
    tgt_col = lcol_q;
    tgt_row = lrow_q;
    unique case (kind_i)
      cldw_pkg::KIND_DRAW: begin
        if (in_area) begin
          {lrow_d, lcol_d} = step_pos(lcol_q, lrow_q, cols_eff, rows_eff);
        end
      end
      cldw_pkg::KIND_CURSOR: begin
        tgt_col = clamp_col;
        tgt_row = clamp_row;
        lcol_d  = clamp_col;
        lrow_d  = clamp_row;
      end
      cldw_pkg::KIND_CLEAR: begin
        lcol_d = '0;
        lrow_d = '0;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lcol_q    <= '0;
      lrow_q    <= '0;
      b_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        lcol_q    <= lcol_d;
        lrow_q    <= lrow_d;
        b_valid_q <= 1'b1;
      end else if (b_adv) begin
        b_valid_q <= 1'b0;
      end
    end
  end

  // Shadow write from the item leaving B while the next one reads the same entry.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      b_kind_q     <= kind_i;
      b_char_q     <= char_byte_i;
      b_col_q      <= tgt_col;
      b_row_q      <= tgt_row;
      b_level_q    <= level_clamp;
      b_hit_q      <= in_area;
      b_addr_q     <= addr_a;
      b_fwd_q      <= b_adv && wr_en && (b_addr_q == addr_a);
      b_fwd_data_q <= b_char_q;
    end
  end

  // ---------------- shadow store ----------------
  logic [7:0]       ram_rdata;
  logic [Depth-1:0] vld_q, vld_d;

  cldw_ram #(
    .WIDTH(8),
    .DEPTH(Depth)
  ) u_shadow (
    .clk_i  (clk_i),
    .we_i   (b_adv && wr_en),
    .waddr_i(b_addr_q),
    .wdata_i(b_char_q),
    .re_i   (accept),
    .raddr_i(addr_a),
    .rdata_o(ram_rdata)
  );

  // ---------------- B stage: physical cursor and byte groups ----------------
  logic            pknown_q, pknown_d;
  logic [ColW-1:0] pcol_q, pcol_d;
  logic [RowW-1:0] prow_q, prow_d;
  logic [7:0]      shadow;
  logic            differ;
  logic            move_need;
  logic [7:0]      move_addr;
  logic            clr_all;
  logic            emit;
  cldw_pkg::cldw_entry_t entry;

  always_comb begin
    if (b_fwd_q) begin
      shadow = b_fwd_data_q;
    end else if (vld_q[b_addr_q]) begin
      shadow = ram_rdata;
    end else begin
      shadow = cldw_pkg::CHAR_SPACE;
    end
  end

  assign differ    = (shadow != b_char_q);
  assign move_need = !pknown_q || (pcol_q != b_col_q) || (prow_q != b_row_q);
  assign move_addr = cldw_pkg::row_base(2'(b_row_q)) + 8'(b_col_q);

  always_comb begin
    emit           = 1'b0;
    wr_en          = 1'b0;
    clr_all        = 1'b0;
    pknown_d       = pknown_q;
    pcol_d         = pcol_q;
    prow_d         = prow_q;
    entry.bytes[0] = cldw_pkg::CMD_PREFIX;
    entry.bytes[1] = cldw_pkg::OP_MOVE;
    entry.bytes[2] = move_addr;
    entry.bytes[3] = b_char_q;
    entry.last_idx = 2'd1;
    unique case (b_kind_q)
      cldw_pkg::KIND_DRAW: begin
        if (b_hit_q && differ) begin
          emit     = 1'b1;
          wr_en    = 1'b1;
          pknown_d = 1'b1;
          {prow_d, pcol_d} = step_pos(b_col_q, b_row_q, cols_eff, rows_eff);
          if (move_need) begin
            entry.last_idx = 2'd3;
          end else begin
            entry.bytes[0] = b_char_q;
            entry.last_idx = 2'd0;
          end
        end
      end
      cldw_pkg::KIND_CURSOR: begin
        if (move_need) begin
          emit           = 1'b1;
          pknown_d       = 1'b1;
          pcol_d         = b_col_q;
          prow_d         = b_row_q;
          entry.last_idx = 2'd2;
        end
      end
      cldw_pkg::KIND_CLEAR: begin
        emit           = 1'b1;
        clr_all        = 1'b1;
        pknown_d       = 1'b1;
        pcol_d         = '0;
        prow_d         = '0;
        entry.bytes[1] = cldw_pkg::OP_CLEAR;
      end
      cldw_pkg::KIND_BRIGHT: begin
        emit           = 1'b1;
        entry.bytes[1] = cldw_pkg::OP_BRIGHT;
        entry.bytes[2] = b_level_q;
        entry.last_idx = 2'd2;
      end
      cldw_pkg::KIND_ON: begin
        emit           = 1'b1;
        entry.bytes[1] = cldw_pkg::OP_ON;
      end
      cldw_pkg::KIND_OFF: begin
        emit           = 1'b1;
        entry.bytes[1] = cldw_pkg::OP_OFF;
      end
      cldw_pkg::KIND_BLINK_ON: begin
        emit           = 1'b1;
        entry.bytes[1] = cldw_pkg::OP_BLINK_ON;
      end
      cldw_pkg::KIND_BLINK_OFF: begin
        emit           = 1'b1;
        entry.bytes[1] = cldw_pkg::OP_BLINK_OFF;
      end
    endcase
  end

  always_comb begin
    vld_d = vld_q;
    if (clr_all) begin
      vld_d = '0;
    end else if (wr_en) begin
      vld_d[b_addr_q] = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pknown_q <= 1'b0;
      pcol_q   <= '0;
      prow_q   <= '0;
      vld_q    <= '0;
    end else if (b_adv) begin
      pknown_q <= pknown_d;
      pcol_q   <= pcol_d;
      prow_q   <= prow_d;
      vld_q    <= vld_d;
    end
  end

  assign push_o.valid = b_adv && emit;
  assign push_o.entry = entry;

endmodule

// ===== sv/cldw_queue.sv =====
// Short FIFO of byte groups between the front end and the serializer.
`timescale 1ns / 1ps
module cldw_queue (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  cldw_pkg::cldw_push_t push_i,
  output logic                 full_o,
  output cldw_pkg::cldw_push_t head_o,
  input  logic                 pop_i
);

  localparam logic [cldw_pkg::QPTR_W-1:0] PtrLast =
    cldw_pkg::QPTR_W'(cldw_pkg::QUEUE_DEPTH - 1);
  localparam logic [cldw_pkg::QCNT_W-1:0] CntFull =
    cldw_pkg::QCNT_W'(cldw_pkg::QUEUE_DEPTH);

  cldw_pkg::cldw_entry_t            slot_q [cldw_pkg::QUEUE_DEPTH];
  logic [cldw_pkg::QPTR_W-1:0]      wr_ptr_q, wr_ptr_d;
  logic [cldw_pkg::QPTR_W-1:0]      rd_ptr_q, rd_ptr_d;
  logic [cldw_pkg::QCNT_W-1:0]      cnt_q, cnt_d;
  logic                             do_push;
  logic                             do_pop;

  assign full_o       = (cnt_q == CntFull);
  assign do_push      = push_i.valid && !full_o;
  assign do_pop       = pop_i && (cnt_q != '0);
  assign head_o.valid = (cnt_q != '0);
  assign head_o.entry = slot_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrLast) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrLast) ? '0 : rd_ptr_q + 1'b1;
    end
    unique case ({do_push, do_pop})
      2'b10:   cnt_d = cnt_q + 1'b1;
      2'b01:   cnt_d = cnt_q - 1'b1;
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_ptr_q] <= push_i.entry;
    end
  end

endmodule

// ===== sv/cldw_back.sv =====
// Back end: sends the queued byte groups one byte per item, marking the last.
`timescale 1ns / 1ps
module cldw_back (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  cldw_pkg::cldw_push_t head_i,
  output logic                 pop_o,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [7:0]           tx_byte_o,
  output logic                 last_o
);

  logic [1:0] idx_q, idx_d;
  logic       fire;

  assign out_valid_o = head_i.valid;
  assign tx_byte_o   = head_i.entry.bytes[idx_q];
  assign last_o      = (idx_q == head_i.entry.last_idx);
  assign fire        = out_valid_o && !out_stall_i;
  assign pop_o       = fire && last_o;

  always_comb begin
    idx_d = idx_q;
    if (fire) begin
      idx_d = last_o ? 2'd0 : idx_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= 2'd0;
    end else begin
      idx_q <= idx_d;
    end
  end

endmodule

// ===== sv/char_lcd_shadow_diff_writer.sv =====
// Top level of the character LCD shadow diff writer.
//
//   channel  dir  handshake                 payload
//   cfg      in   cfg_we_i                  cfg_idx_i, cfg_data_i
//   in       in   in_valid_i / in_stall_o   kind_i, char_byte_i, col_i, row_i, level_i
//   out      out  out_valid_o / out_stall_i tx_byte_o, last_o
//
// A request is taken every cycle while the two-entry byte queue has room; the
// serializer sends one byte per cycle while out_stall_i is low, so a request
// yields 0 to 4 bytes (a draw with cursor move is the four-byte case). The first
// byte is presented after the B stage (shadow read) and the registered queue head.
// Reset clears the shadow valid flags at once; no sweep is needed.
// out_stall_i holds the current byte; a full queue with B occupied raises in_stall_o.
`timescale 1ns / 1ps
`include "char_lcd_shadow_diff_writer_macros.svh"
module char_lcd_shadow_diff_writer #(
  parameter int MAX_COLS = 20,
  parameter int MAX_ROWS = 4
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [cldw_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [cldw_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic [2:0]                      kind_i,
  input  logic [7:0]                      char_byte_i,
  input  logic [7:0]                      col_i,
  input  logic [7:0]                      row_i,
  input  logic [7:0]                      level_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [7:0]                      tx_byte_o,
  output logic                            last_o
);

  logic [4:0] cols_q;
  logic [2:0] rows_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cols_q <= cldw_pkg::COLS_RST;
      rows_q <= cldw_pkg::ROWS_RST;
    end else if (cfg_we_i) begin
      unique case (cldw_pkg::cldw_cfg_e'(cfg_idx_i))
        cldw_pkg::CFG_COLS: cols_q <= cfg_data_i[4:0];
        cldw_pkg::CFG_ROWS: rows_q <= cfg_data_i[2:0];
      endcase
    end
  end

  cldw_pkg::cldw_push_t push;
  cldw_pkg::cldw_push_t head;
  logic                 q_full;
  logic                 pop;

  cldw_front #(
    .MAX_COLS(MAX_COLS),
    .MAX_ROWS(MAX_ROWS)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_cols_i (cols_q),
    .cfg_rows_i (rows_q),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .kind_i     (cldw_pkg::cldw_kind_e'(kind_i)),
    .char_byte_i(char_byte_i),
    .col_i      (col_i),
    .row_i      (row_i),
    .level_i    (level_i),
    .q_full_i   (q_full),
    .push_o     (push)
  );

  cldw_queue u_queue (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .push_i(push),
    .full_o(q_full),
    .head_o(head),
    .pop_i (pop)
  );

  cldw_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .head_i     (head),
    .pop_o      (pop),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .tx_byte_o  (tx_byte_o),
    .last_o     (last_o)
  );

  // Front end must never hand a group to a full queue.
  `CLDW_ASSERT_NOW(a_no_push_when_full, push.valid, !q_full, "push into full byte queue")
  // A group stays at the head until its last byte is taken.
  `CLDW_ASSERT_NEXT(a_group_continues, out_valid_o && !out_stall_i && !last_o, out_valid_o,
                    "byte group dropped before its last byte")
  // Popping only happens on the final byte of a group.
  `CLDW_ASSERT_NOW(a_pop_on_last, pop, last_o && out_valid_o, "queue popped mid-group")

endmodule

// ===== verif/char_lcd_shadow_diff_writer_checker.sv =====
// Byte-stream predictor and checker for the character LCD shadow diff writer.
`timescale 1ns / 1ps
module char_lcd_shadow_diff_writer_checker #(
  parameter int MAX_COLS = 20,
  parameter int MAX_ROWS = 4
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [cldw_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [cldw_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic                            in_valid_i,
  input  logic                            in_stall_i,
  input  logic [2:0]                      kind_i,
  input  logic [7:0]                      char_byte_i,
  input  logic [7:0]                      col_i,
  input  logic [7:0]                      row_i,
  input  logic [7:0]                      level_i,
  input  logic                            out_valid_i,
  input  logic                            out_stall_i,
  input  logic [7:0]                      tx_byte_i,
  input  logic                            last_i,
  output int                              fail_count_o,
  output int                              pending_o
);

  typedef struct {
    logic [7:0] tx;
    logic       last;
  } lcd_byte_t;

  lcd_byte_t  tx_expect_q[$];
  lcd_byte_t  oldest;
  logic [7:0] req_bytes[$];
  logic [7:0] screen_shadow[MAX_ROWS*MAX_COLS];
  int         cur_col;
  int         cur_row;
  int         lcd_col;
  int         lcd_row;
  bit         lcd_pos_known;
  logic [4:0] cols_cfg;
  logic [2:0] rows_cfg;
  int         fail_count = 0;

  // Cursor-move command; DDRAM rows start at 0x00, 0x40, 0x14, 0x54.
  task automatic move_lcd_cursor(input int c, input int r);
    logic [7:0] addr;
    addr = 8'(c) + (((r & 1) != 0) ? 8'h40 : 8'h00) + (((r & 2) != 0) ? 8'h14 : 8'h00);
    req_bytes.push_back(cldw_pkg::CMD_PREFIX);
    req_bytes.push_back(cldw_pkg::OP_MOVE);
    req_bytes.push_back(addr);
    lcd_col       = c;
    lcd_row       = r;
    lcd_pos_known = 1'b1;
  endtask

  task automatic predict_request(input cldw_pkg::cldw_kind_e kind, input logic [7:0] ch,
                                 input logic [7:0] col, input logic [7:0] row,
                                 input logic [7:0] level);
    int         cols;
    int         rows;
    int         idx;
    int         c;
    int         r;
    logic [7:0] lvl;
    cols = (cols_cfg == 0) ? 1 : (cols_cfg > MAX_COLS) ? MAX_COLS : int'(cols_cfg);
    rows = (rows_cfg == 0) ? 1 : (rows_cfg > MAX_ROWS) ? MAX_ROWS : int'(rows_cfg);
    req_bytes.delete();
    case (kind)
      cldw_pkg::KIND_DRAW: begin
        // a cursor left outside a shrunken area makes draws no-ops
        if (cur_row < rows && cur_col < cols) begin
          idx = cur_row * MAX_COLS + cur_col;
          if (screen_shadow[idx] != ch) begin
            if (!lcd_pos_known || lcd_col != cur_col || lcd_row != cur_row) begin
              move_lcd_cursor(cur_col, cur_row);
            end
            req_bytes.push_back(ch);
            screen_shadow[idx] = ch;
            lcd_col++;
            if (lcd_col >= cols) begin
              lcd_col = 0;
              lcd_row = (lcd_row + 1) % rows;
            end
          end
          cur_col++;
          if (cur_col >= cols) begin
            cur_col = 0;
            cur_row = (cur_row + 1) % rows;
          end
        end
      end
      cldw_pkg::KIND_CURSOR: begin
        c = (int'(col) < cols) ? int'(col) : cols - 1;
        r = (int'(row) < rows) ? int'(row) : rows - 1;
        cur_col = c;
        cur_row = r;
        if (!lcd_pos_known || lcd_col != c || lcd_row != r) begin
          move_lcd_cursor(c, r);
        end
      end
      cldw_pkg::KIND_CLEAR: begin
        req_bytes.push_back(cldw_pkg::CMD_PREFIX);
        req_bytes.push_back(cldw_pkg::OP_CLEAR);
        foreach (screen_shadow[i]) screen_shadow[i] = cldw_pkg::CHAR_SPACE;
        cur_col       = 0;
        cur_row       = 0;
        lcd_col       = 0;
        lcd_row       = 0;
        lcd_pos_known = 1'b1;
      end
      cldw_pkg::KIND_BRIGHT: begin
        lvl = (level < cldw_pkg::LEVEL_MIN) ? cldw_pkg::LEVEL_MIN :
              (level > cldw_pkg::LEVEL_MAX) ? cldw_pkg::LEVEL_MAX : level;
        req_bytes.push_back(cldw_pkg::CMD_PREFIX);
        req_bytes.push_back(cldw_pkg::OP_BRIGHT);
        req_bytes.push_back(lvl);
      end
      cldw_pkg::KIND_ON: begin
        req_bytes.push_back(cldw_pkg::CMD_PREFIX);
        req_bytes.push_back(cldw_pkg::OP_ON);
      end
      cldw_pkg::KIND_OFF: begin
        req_bytes.push_back(cldw_pkg::CMD_PREFIX);
        req_bytes.push_back(cldw_pkg::OP_OFF);
      end
      cldw_pkg::KIND_BLINK_ON: begin
        req_bytes.push_back(cldw_pkg::CMD_PREFIX);
        req_bytes.push_back(cldw_pkg::OP_BLINK_ON);
      end
      default: begin
        req_bytes.push_back(cldw_pkg::CMD_PREFIX);
        req_bytes.push_back(cldw_pkg::OP_BLINK_OFF);
      end
    endcase
    foreach (req_bytes[i]) begin
      tx_expect_q.push_back('{tx: req_bytes[i], last: (i == req_bytes.size() - 1)});
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      foreach (screen_shadow[i]) screen_shadow[i] = cldw_pkg::CHAR_SPACE;
      cur_col       = 0;
      cur_row       = 0;
      lcd_col       = 0;
      lcd_row       = 0;
      lcd_pos_known = 1'b0;
      cols_cfg      = cldw_pkg::COLS_RST;
      rows_cfg      = cldw_pkg::ROWS_RST;
      tx_expect_q.delete();
    end else begin
      if (cfg_we_i) begin
        case (cldw_pkg::cldw_cfg_e'(cfg_idx_i))
          cldw_pkg::CFG_COLS: cols_cfg = cfg_data_i[4:0];
          cldw_pkg::CFG_ROWS: rows_cfg = cfg_data_i[2:0];
          default: ;
        endcase
      end
      if (in_valid_i && !in_stall_i) begin
        predict_request(cldw_pkg::cldw_kind_e'(kind_i), char_byte_i, col_i, row_i, level_i);
      end
      if (out_valid_i && !out_stall_i) begin
        if (tx_expect_q.size() == 0) begin
          $display("%0t: unexpected item, tx_byte %02h last %0b", $time, tx_byte_i, last_i);
          fail_count++;
        end else begin
          oldest = tx_expect_q.pop_front();
          if (tx_byte_i !== oldest.tx) begin
            $display("%0t: tx_byte expected %02h actual %02h", $time, oldest.tx, tx_byte_i);
            fail_count++;
          end
          if (last_i !== oldest.last) begin
            $display("%0t: last expected %0b actual %0b", $time, oldest.last, last_i);
            fail_count++;
          end
        end
      end
    end
    pending_o    <= tx_expect_q.size();
    fail_count_o <= fail_count;
  end

endmodule

// ===== verif/testbench.sv =====
// Top of the testbench: stimulus, clock and reset, and the verdict.
`timescale 1ns / 1ps
module testbench;

  localparam int CYCLE_LIMIT  = 200000;
  localparam int DRAIN_CYCLES = 12;
  localparam int SEG_ITEMS    = 26;

  logic                            clk_i = 1'b0;
  logic                            rst_ni;
  logic                            cfg_we_i;
  logic [cldw_pkg::CFG_IDX_W-1:0]  cfg_idx_i;
  logic [cldw_pkg::CFG_DATA_W-1:0] cfg_data_i;
  logic                            in_valid_i;
  logic                            in_stall_o;
  logic [2:0]                      kind_i;
  logic [7:0]                      char_byte_i;
  logic [7:0]                      col_i;
  logic [7:0]                      row_i;
  logic [7:0]                      level_i;
  logic                            out_valid_o;
  logic                            out_stall_i;
  logic [7:0]                      tx_byte_o;
  logic                            last_o;
  int                              fail_count;
  int                              pending;
  int                              cycles = 0;
  bit                              no_idle = 1'b0;

  char_lcd_shadow_diff_writer dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .in_valid_i, .in_stall_o, .kind_i, .char_byte_i, .col_i, .row_i, .level_i,
    .out_valid_o, .out_stall_i, .tx_byte_o, .last_o
  );

  char_lcd_shadow_diff_writer_checker lcd_stream_check (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .in_valid_i, .in_stall_i(in_stall_o), .kind_i, .char_byte_i, .col_i, .row_i,
    .level_i, .out_valid_i(out_valid_o), .out_stall_i, .tx_byte_i(tx_byte_o),
    .last_i(last_o), .fail_count_o(fail_count), .pending_o(pending)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Receiver: random stall before each item.
  initial begin
    int hold;
    out_stall_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      hold = no_idle ? 0 : $urandom_range(0, 10);
      if (hold > 0) begin
        out_stall_i <= 1'b1;
        repeat (hold) @(negedge clk_i);
      end
      out_stall_i <= 1'b0;
      do @(posedge clk_i); while (!out_valid_o);
    end
  end

  // Called at a falling edge; returns at the falling edge after acceptance.
  task automatic push_request(input cldw_pkg::cldw_kind_e kind, input logic [7:0] ch,
                              input logic [7:0] col, input logic [7:0] row,
                              input logic [7:0] level);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 10);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i  <= 1'b1;
    kind_i      <= kind;
    char_byte_i <= ch;
    col_i       <= col;
    row_i       <= row;
    level_i     <= level;
    do @(posedge clk_i); while (in_stall_o);
    @(negedge clk_i);
  endtask

  // Hold off until every predicted byte is out, plus slack for no-byte draws.
  task automatic wait_for_drain();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  task automatic set_geometry(input logic [4:0] cols, input logic [4:0] rows);
    wait_for_drain();
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= cldw_pkg::CFG_COLS;
    cfg_data_i <= cols;
    @(negedge clk_i);
    cfg_idx_i  <= cldw_pkg::CFG_ROWS;
    cfg_data_i <= rows;
    @(negedge clk_i);
    cfg_we_i   <= 1'b0;
  endtask

  initial begin
    int                   seg_cols[7];
    int                   seg_rows[7];
    int                   eff_c;
    int                   eff_r;
    int                   pick;
    cldw_pkg::cldw_kind_e kind;
    logic [7:0]           ch;
    logic [7:0]           col;
    logic [7:0]           row;
    logic [7:0]           level;

    rst_ni      = 1'b0;
    cfg_we_i    = 1'b0;
    cfg_idx_i   = cldw_pkg::CFG_COLS;
    cfg_data_i  = '0;
    in_valid_i  = 1'b0;
    kind_i      = cldw_pkg::KIND_DRAW;
    char_byte_i = '0;
    col_i       = '0;
    row_i       = '0;
    level_i     = '0;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed part, reset geometry 20x4
    push_request(cldw_pkg::KIND_ON, 8'h00, 8'h00, 8'h00, 8'h00);
    push_request(cldw_pkg::KIND_OFF, 8'h00, 8'h00, 8'h00, 8'h00);
    push_request(cldw_pkg::KIND_BLINK_ON, 8'h00, 8'h00, 8'h00, 8'h00);
    push_request(cldw_pkg::KIND_BLINK_OFF, 8'h00, 8'h00, 8'h00, 8'h00);
    push_request(cldw_pkg::KIND_BRIGHT, 8'h00, 8'h00, 8'h00, 8'h00);
    push_request(cldw_pkg::KIND_BRIGHT, 8'h00, 8'h00, 8'h00, 8'h05);
    push_request(cldw_pkg::KIND_BRIGHT, 8'h00, 8'h00, 8'h00, 8'h08);
    push_request(cldw_pkg::KIND_BRIGHT, 8'h00, 8'h00, 8'h00, 8'h09);
    push_request(cldw_pkg::KIND_BRIGHT, 8'h00, 8'h00, 8'h00, 8'hFF);
    // position unknown after reset: move plus char
    push_request(cldw_pkg::KIND_DRAW, 8'h41, 8'h00, 8'h00, 8'h00);
    // unchanged character: no bytes
    push_request(cldw_pkg::KIND_DRAW, cldw_pkg::CHAR_SPACE, 8'h00, 8'h00, 8'h00);
    push_request(cldw_pkg::KIND_CURSOR, 8'h00, 8'hFF, 8'hFF, 8'h00);
    // bottom-right corner, both cursors wrap to home
    push_request(cldw_pkg::KIND_DRAW, 8'hFF, 8'h00, 8'h00, 8'h00);
    push_request(cldw_pkg::KIND_DRAW, 8'h00, 8'h00, 8'h00, 8'h00);
    // physical cursor already there: no bytes
    push_request(cldw_pkg::KIND_CURSOR, 8'h00, 8'h01, 8'h00, 8'h00);
    push_request(cldw_pkg::KIND_CLEAR, 8'h00, 8'h00, 8'h00, 8'h00);
    push_request(cldw_pkg::KIND_DRAW, 8'h78, 8'h00, 8'h00, 8'h00);
    // zero registers act as 1x1; logical cursor is now outside the area
    set_geometry(5'd0, 5'd0);
    push_request(cldw_pkg::KIND_DRAW, 8'h51, 8'h00, 8'h00, 8'h00);
    push_request(cldw_pkg::KIND_CURSOR, 8'h00, 8'h05, 8'h05, 8'h00);
    push_request(cldw_pkg::KIND_DRAW, 8'h71, 8'h00, 8'h00, 8'h00);
    push_request(cldw_pkg::KIND_DRAW, 8'h72, 8'h00, 8'h00, 8'h00);
    // oversized registers clamp to 20x4
    set_geometry(5'd31, 5'd7);
    push_request(cldw_pkg::KIND_BLINK_OFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
    push_request(cldw_pkg::KIND_DRAW, 8'h00, 8'h00, 8'h00, 8'h00);

    seg_cols = '{20, 1, 31, 5, 0, 0, 13};
    seg_rows = '{4, 1, 7, 2, 0, 0, 3};
    seg_cols[4] = $urandom_range(0, 31);
    seg_rows[4] = $urandom_range(0, 31);
    for (int seg = 0; seg < 7; seg++) begin
      set_geometry(5'(seg_cols[seg]), 5'(seg_rows[seg]));
      no_idle = (seg == 2 || seg == 5);
      eff_c = (seg_cols[seg] == 0) ? 1 : (seg_cols[seg] > 20) ? 20 : seg_cols[seg];
      eff_r = ((seg_rows[seg] & 7) == 0) ? 1 : ((seg_rows[seg] & 7) > 4) ? 4 :
              (seg_rows[seg] & 7);
      for (int n = 0; n < SEG_ITEMS; n++) begin
        pick = $urandom_range(0, 99);
        if (pick < 55)      kind = cldw_pkg::KIND_DRAW;
        else if (pick < 72) kind = cldw_pkg::KIND_CURSOR;
        else if (pick < 76) kind = cldw_pkg::KIND_CLEAR;
        else if (pick < 84) kind = cldw_pkg::KIND_BRIGHT;
        else                kind = cldw_pkg::cldw_kind_e'($urandom_range(4, 7));
        // narrow alphabet so unchanged-character draws happen often
        ch    = ($urandom_range(0, 2) == 0) ? 8'($urandom) : 8'h20 + 8'($urandom_range(0, 2));
        col   = ($urandom_range(0, 4) == 0) ? 8'($urandom) : 8'($urandom_range(0, eff_c - 1));
        row   = ($urandom_range(0, 4) == 0) ? 8'($urandom) : 8'($urandom_range(0, eff_r - 1));
        level = ($urandom_range(0, 1) == 0) ? 8'($urandom) : 8'($urandom_range(0, 9));
        push_request(kind, ch, col, row, level);
      end
    end
    no_idle = 1'b0;

    wait_for_drain();
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
